### rtl/gat_pkg.sv
// Package: shared types, constants and command codes of the group association table
`default_nettype none
package gat_pkg;

    localparam int GAT_MAX_ENTRIES = 256;
    localparam int GAT_QUEUE_DEPTH = 2;
    localparam int IDX_W = 9;
    localparam int VAL_W = 16;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_FORWARD = 2'd1;
    localparam logic [1:0] CMD_REVERSE = 2'd2;

    typedef enum logic [1:0] {
        OP_IMM   = 2'd0,
        OP_WRITE = 2'd1,
        OP_FWD   = 2'd2,
        OP_REV   = 2'd3
    } t_op_kind;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] transport_addr;
        logic [VAL_W-1:0] object_number;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] mapped_value;
        logic [IDX_W-1:0] resume_index;
    } t_out_item;

    // decoded operation handed from the front to the back
    typedef struct packed {
        t_op_kind         kind;
        t_out_item        res;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] stop;
        logic [VAL_W-1:0] tsap;
        logic [VAL_W-1:0] asap;
    } t_op;

endpackage
`default_nettype wire

### rtl/gat_front.sv
// Front end: classifies an incoming transaction into a decoded table operation
`default_nettype none
module gat_front
    import gat_pkg::*;
#(
    parameter int MAX_ENTRIES = GAT_MAX_ENTRIES
) (
    input  wire t_in_item         i_item,
    input  wire logic [IDX_W-1:0] i_entries,
    output t_op                   o_op
);

    logic [IDX_W-1:0] cnt;
    logic             idx_in_range;

    always_comb begin
        cnt          = (32'(i_entries) > MAX_ENTRIES) ? IDX_W'(MAX_ENTRIES) : i_entries;
        idx_in_range = 32'(i_item.entry_index) < MAX_ENTRIES;

        o_op.kind             = OP_IMM;
        o_op.res.found        = 1'b0;
        o_op.res.mapped_value = '0;
        o_op.res.resume_index = i_item.entry_index;
        o_op.start            = i_item.entry_index;
        o_op.stop             = cnt;
        o_op.tsap             = i_item.transport_addr;
        o_op.asap             = i_item.object_number;

        unique case (i_item.cmd)
            CMD_WRITE: begin
                if (idx_in_range) begin
                    o_op.kind = OP_WRITE;
                end
            end
            CMD_FORWARD: begin
                if (cnt == '0) begin
                    if (i_item.entry_index == '0) begin
                        o_op.res.found        = 1'b1;
                        o_op.res.mapped_value = i_item.transport_addr;
                        o_op.res.resume_index = IDX_W'(1);
                    end
                end else if (i_item.entry_index < cnt) begin
                    o_op.kind = OP_FWD;
                end
            end
            CMD_REVERSE: begin
                if (cnt == '0) begin
                    o_op.res.found        = 1'b1;
                    o_op.res.mapped_value = i_item.object_number;
                end else begin
                    o_op.kind  = OP_REV;
                    o_op.start = '0;
                end
            end
            default: begin
                o_op.kind = OP_IMM;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/gat_queue.sv
// Short queue of decoded operations between the front and the back
`default_nettype none
module gat_queue
    import gat_pkg::*;
#(
    parameter int DEPTH = GAT_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op            r_buf [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic [CW-1:0]  n_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_buf[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_op;
        end
    end

endmodule
`default_nettype wire

### rtl/gat_back.sv
// Back end: pair memory, sequential table scan and output register
`default_nettype none
module gat_back
    import gat_pkg::*;
#(
    parameter int MAX_ENTRIES = GAT_MAX_ENTRIES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_op  i_q_op,
    output logic      o_q_pop,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_item o_item
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [2*VAL_W-1:0] r_mem [MAX_ENTRIES];
    logic [2*VAL_W-1:0] r_rdata;
    t_op                r_op;
    logic [IDX_W-1:0]   r_ptr;
    logic [IDX_W-1:0]   n_ptr;
    logic               r_rd_vld;
    logic               n_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;
    t_out_item          r_res;
    t_out_item          n_res;
    logic               r_out_vld;
    t_out_item          r_out;
    t_out_item          out_data;
    logic               out_free;
    logic               load_out;
    logic               mem_we;
    logic               take_op;
    logic               issue;
    logic               hit;
    logic [VAL_W-1:0]   rd_tsap;
    logic [VAL_W-1:0]   rd_asap;

    assign out_free = !r_out_vld || !i_stall;
    assign rd_tsap  = r_rdata[2*VAL_W-1:VAL_W];
    assign rd_asap  = r_rdata[VAL_W-1:0];
    assign hit      = (r_op.kind == OP_FWD) ? (rd_tsap == r_op.tsap) : (rd_asap == r_op.asap);
    assign o_valid  = r_out_vld;
    assign o_item   = r_out;

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_rd_vld = 1'b0;
        n_res    = r_res;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        out_data = r_res;
        mem_we   = 1'b0;
        take_op  = 1'b0;
        issue    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_op.kind) inside
                        OP_IMM, OP_WRITE: begin
                            if (out_free) begin
                                o_q_pop  = 1'b1;
                                load_out = 1'b1;
                                out_data = i_q_op.res;
                                mem_we   = i_q_op.kind == OP_WRITE;
                            end
                        end
                        OP_FWD, OP_REV: begin
                            o_q_pop = 1'b1;
                            take_op = 1'b1;
                            n_ptr   = i_q_op.start;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ptr < r_op.stop) begin
                    issue    = 1'b1;
                    n_ptr    = r_ptr + IDX_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    if (hit) begin
                        n_res.found = 1'b1;
                        if (r_op.kind == OP_FWD) begin
                            n_res.mapped_value = rd_asap;
                            n_res.resume_index = r_rd_idx + IDX_W'(1);
                        end else begin
                            n_res.mapped_value = rd_tsap;
                        end
                        n_rd_vld = 1'b0;
                        n_state  = S_DONE;
                    end else if ((r_rd_idx + IDX_W'(1)) == r_op.stop) begin
                        // miss: forward resumes at the count, reverse echoes the index
                        if (r_op.kind == OP_FWD) begin
                            n_res.resume_index = r_op.stop;
                        end
                        n_rd_vld = 1'b0;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (take_op) begin
            n_res = i_q_op.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_res <= n_res;
        if (take_op) begin
            r_op <= i_q_op;
        end
        if (issue) begin
            r_rd_idx <= r_ptr;
        end
        if (load_out) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(i_q_op.start)] <= {i_q_op.tsap, i_q_op.asap};
        end
        r_rdata <= r_mem[AW'(r_ptr)];
    end

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_op.stop))
        else $error("scan pointer past entry count");

    a_rd_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (32'(r_rd_idx) < MAX_ENTRIES))
        else $error("scan read outside table");

    a_fwd_resume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.found && r_op.kind == OP_FWD)
            |-> (r_res.resume_index != '0))
        else $error("forward hit with zero resume index");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE && i_q_valid))
        else $error("queue popped outside idle");

endmodule
`default_nettype wire

### rtl/group_association_table_lookup.sv
// Top level: group association table with forward and reverse lookup
// A write or an answer settled at decode passes through the queue and then the output register.
// A scan over n pairs passes through the queue, S_SCAN, S_DONE and the output register; n is
// count - start at most for forward, count at most for reverse. One pair is compared per
// cycle through the single read port; the back takes the next transaction from S_IDLE after
// the output register is loaded. The queue lets the front accept up to its depth ahead.
// Reset clears the entry count to 0 and empties queue and output; pair memory is not cleared.
`default_nettype none
module group_association_table_lookup
    import gat_pkg::*;
#(
    parameter int MAX_ENTRIES = GAT_MAX_ENTRIES,
    parameter int QUEUE_DEPTH = GAT_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [IDX_W-1:0] i_cfg_data
);

    logic [IDX_W-1:0] r_entries;
    t_op              front_op;
    t_op              q_op;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entries <= i_cfg_data;
        end
    end

    gat_front #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_front (
        .i_item   (i_in_item),
        .i_entries(r_entries),
        .o_op     (front_op)
    );

    gat_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_in_valid),
        .i_op   (front_op),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_op   (q_op),
        .i_pop  (q_pop)
    );

    gat_back #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_op   (q_op),
        .o_q_pop  (q_pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item)
    );

endmodule
`default_nettype wire
